### hdl/gcmb_pkg.sv
// ---------------------------------------------------------------------------
// gcmb_pkg
// Shared constants, request codes and types of the heap mark bitmap.
// ---------------------------------------------------------------------------
`default_nettype none

package gcmb_pkg;

  localparam int unsigned HEAP_WORDS_DEF = 4096;
  localparam int unsigned ADDR_W         = 48;
  localparam int unsigned REQ_W          = 3;
  localparam int unsigned STORE_W        = 64;
  localparam int unsigned SLOT_W         = ADDR_W - 6;

  localparam logic [REQ_W-1:0] REQ_MARK   = 3'd0;
  localparam logic [REQ_W-1:0] REQ_UNMARK = 3'd1;
  localparam logic [REQ_W-1:0] REQ_TEST   = 3'd2;
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 3'd3;
  localparam logic [REQ_W-1:0] REQ_SCAN   = 3'd4;

  // Outcome of a find-first-set search over one store word.
  typedef struct packed {
    logic       any;
    logic [5:0] bit_idx;
  } ffs_res_t;

endpackage

`default_nettype wire

### hdl/gcmb_ram.sv
// ---------------------------------------------------------------------------
// gcmb_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ---------------------------------------------------------------------------
`default_nettype none

module gcmb_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    // The read data holds until the next read is issued.
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### hdl/gcmb_ffs.sv
// ---------------------------------------------------------------------------
// gcmb_ffs
// Two-step find-first-set over a 64-bit word: the first non-zero byte is
// picked and registered, then the lowest set bit within it is resolved.
// ---------------------------------------------------------------------------
`default_nettype none

module gcmb_ffs (
  input  wire logic                  clk_i,
  input  wire logic [63:0]           word_i,
  output gcmb_pkg::ffs_res_t         res_o
);

  logic [7:0] byte_nz;
  logic [2:0] byte_idx_d;
  logic [7:0] byte_d;
  logic [2:0] byte_idx_q;
  logic [7:0] byte_q;
  logic       any_q;
  logic [2:0] bit_in_byte;

  always_comb begin
    byte_idx_d = 3'd0;
    for (int i = 0; i < 8; i++) begin
      byte_nz[i] = |word_i[i*8 +: 8];
    end
    for (int i = 7; i >= 0; i--) begin
      if (byte_nz[i]) begin
        byte_idx_d = 3'(i);
      end
    end
    byte_d = word_i[byte_idx_d*8 +: 8];
  end

  always_ff @(posedge clk_i) begin
    byte_idx_q <= byte_idx_d;
    byte_q     <= byte_d;
    any_q      <= |byte_nz;
  end

  always_comb begin
    bit_in_byte = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (byte_q[i]) begin
        bit_in_byte = 3'(i);
      end
    end
    res_o.any     = any_q;
    res_o.bit_idx = {byte_idx_q, bit_in_byte};
  end

endmodule

`default_nettype wire

### hdl/gc_mark_bitmap.sv
// Mark, unmark and test pass the read, modify and done states; the result is
// registered on leaving done, and no new request is taken until then. Out-of-range
// and unused requests go straight to done. Scan runs read, byte pick and bit pick
// for each store word examined, then done; clear all writes the store words in turn
// through the single write port of the store, then done. After reset the store is
// swept to zero; input stalls meanwhile, configuration writes are taken at any time.
// ---------------------------------------------------------------------------
// gc_mark_bitmap
// Heap mark bitmap: one mark bit per 8-byte word, held in a 64-bit wide RAM,
// with mark, unmark, test, clear-all and scan-forward requests.
// ---------------------------------------------------------------------------
`default_nettype none

module gc_mark_bitmap #(
  parameter int unsigned HEAP_WORDS = gcmb_pkg::HEAP_WORDS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // configuration
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [gcmb_pkg::ADDR_W-1:0]   cfg_heap_base_i,
  // requests
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [gcmb_pkg::REQ_W-1:0]    in_req_type_i,
  input  wire logic [gcmb_pkg::ADDR_W-1:0]   in_address_i,
  // results
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic                               out_found_o,
  output logic      [gcmb_pkg::ADDR_W-1:0]   out_result_address_o,
  output logic                               out_out_of_range_o
);

  localparam int unsigned STORE_WORDS = (HEAP_WORDS + 63) / 64;
  localparam int unsigned WA_W        = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
  localparam int unsigned IW          = WA_W + 6;
  localparam int unsigned FULL_W      = gcmb_pkg::ADDR_W - 3;
  localparam int unsigned SW          = gcmb_pkg::SLOT_W;
  localparam int unsigned AW          = gcmb_pkg::ADDR_W;
  localparam int unsigned DW          = gcmb_pkg::STORE_W;
  localparam logic [WA_W-1:0] LAST_WORD = WA_W'(STORE_WORDS - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CLEAR = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_MOD   = 3'd3;
  localparam logic [2:0] S_SEVAL = 3'd4;
  localparam logic [2:0] S_SRES  = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  // control state
  logic [2:0]               state_q, state_d;
  logic [WA_W-1:0]          clr_cnt_q, clr_cnt_d;
  logic                     clr_req_q, clr_req_d;
  logic                     first_q, first_d;
  logic                     out_valid_q, out_valid_d;
  logic [AW-1:0]            base_q;
  // payload
  logic [gcmb_pkg::REQ_W-1:0] req_q, req_d;
  logic [WA_W-1:0]          word_q, word_d;
  logic [5:0]               off_q, off_d;
  logic                     res_found_q, res_found_d;
  logic [AW-1:0]            res_addr_q, res_addr_d;
  logic                     res_oor_q, res_oor_d;
  logic                     out_found_q, out_found_d;
  logic [AW-1:0]            out_addr_q, out_addr_d;
  logic                     out_oor_q, out_oor_d;

  // index calculation
  logic                     in_xfer;
  logic [SW:0]              slot_diff;
  logic [FULL_W-1:0]        idx_full;
  logic                     in_oor;

  // store access
  logic                     ram_we, ram_re;
  logic [WA_W-1:0]          ram_waddr;
  logic [DW-1:0]            ram_wdata, ram_rdata;
  logic [DW-1:0]            bit_mask;
  logic [DW-1:0]            scan_word;
  gcmb_pkg::ffs_res_t       ffs_res;
  logic [IW-1:0]            hit_idx;
  logic                     hit_ok;
  logic                     out_free;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;

  // A borrow out of the slot difference means the address lies below the heap.
  assign slot_diff = {1'b0, in_address_i[AW-1:6]} - {1'b0, base_q[AW-1:6]};
  assign idx_full  = {slot_diff[SW-1:0], in_address_i[5:3]};
  assign in_oor    = slot_diff[SW] || (idx_full >= FULL_W'(HEAP_WORDS));

  assign bit_mask  = DW'(1) << off_q;
  assign scan_word = first_q ? (ram_rdata & ({DW{1'b1}} << off_q)) : ram_rdata;
  assign hit_idx   = {word_q, ffs_res.bit_idx};
  assign hit_ok    = ffs_res.any && ({1'b0, hit_idx} < (IW + 1)'(HEAP_WORDS));

  always_comb begin
    ram_re    = (state_q == S_READ);
    ram_we    = (state_q == S_CLEAR) ||
                ((state_q == S_MOD) &&
                 ((req_q == gcmb_pkg::REQ_MARK) || (req_q == gcmb_pkg::REQ_UNMARK)));
    ram_waddr = (state_q == S_CLEAR) ? clr_cnt_q : word_q;
    if (state_q == S_CLEAR) begin
      ram_wdata = '0;
    end else if (req_q == gcmb_pkg::REQ_MARK) begin
      ram_wdata = ram_rdata | bit_mask;
    end else begin
      ram_wdata = ram_rdata & ~bit_mask;
    end
  end

  gcmb_ram #(
    .WIDTH (DW),
    .DEPTH (STORE_WORDS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (word_q),
    .rdata_o (ram_rdata)
  );

  gcmb_ffs u_ffs (
    .clk_i  (clk_i),
    .word_i (scan_word),
    .res_o  (ffs_res)
  );

  always_comb begin
    state_d     = state_q;
    clr_cnt_d   = clr_cnt_q;
    clr_req_d   = clr_req_q;
    first_d     = first_q;
    req_d       = req_q;
    word_d      = word_q;
    off_d       = off_q;
    res_found_d = res_found_q;
    res_addr_d  = res_addr_q;
    res_oor_d   = res_oor_q;
    out_found_d = out_found_q;
    out_addr_d  = out_addr_q;
    out_oor_d   = out_oor_q;
    out_valid_d = out_valid_q && out_stall_i;

    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          req_d       = in_req_type_i;
          word_d      = idx_full[IW-1:6];
          off_d       = idx_full[5:0];
          first_d     = 1'b1;
          res_found_d = 1'b0;
          res_addr_d  = '0;
          res_oor_d   = 1'b0;
          if (in_req_type_i == gcmb_pkg::REQ_CLEAR) begin
            clr_cnt_d = '0;
            clr_req_d = 1'b1;
            state_d   = S_CLEAR;
          end else if (in_req_type_i > gcmb_pkg::REQ_SCAN) begin
            state_d = S_DONE;
          end else if (in_oor) begin
            res_oor_d = 1'b1;
            state_d   = S_DONE;
          end else begin
            state_d = S_READ;
          end
        end
      end
      S_CLEAR: begin
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == LAST_WORD) begin
          clr_req_d = 1'b0;
          state_d   = clr_req_q ? S_DONE : S_IDLE;
        end
      end
      S_READ: begin
        state_d = (req_q == gcmb_pkg::REQ_SCAN) ? S_SEVAL : S_MOD;
      end
      S_MOD: begin
        if (req_q == gcmb_pkg::REQ_TEST) begin
          res_found_d = |(ram_rdata & bit_mask);
        end
        state_d = S_DONE;
      end
      S_SEVAL: begin
        state_d = S_SRES;
      end
      S_SRES: begin
        if (hit_ok) begin
          res_found_d = 1'b1;
          res_addr_d  = {base_q[AW-1:6] + SW'(hit_idx[IW-1:3]), hit_idx[2:0], 3'b000};
          state_d     = S_DONE;
        end else if (ffs_res.any || (word_q == LAST_WORD)) begin
          state_d = S_DONE;
        end else begin
          word_d  = word_q + 1'b1;
          first_d = 1'b0;
          state_d = S_READ;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_found_d = res_found_q;
          out_addr_d  = res_addr_q;
          out_oor_d   = res_oor_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_cnt_q   <= '0;
      clr_req_q   <= 1'b0;
      first_q     <= 1'b0;
      out_valid_q <= 1'b0;
      base_q      <= '0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      clr_req_q   <= clr_req_d;
      first_q     <= first_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        base_q <= cfg_heap_base_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q       <= req_d;
    word_q      <= word_d;
    off_q       <= off_d;
    res_found_q <= res_found_d;
    res_addr_q  <= res_addr_d;
    res_oor_q   <= res_oor_d;
    out_found_q <= out_found_d;
    out_addr_q  <= out_addr_d;
    out_oor_q   <= out_oor_d;
  end

  assign out_valid_o          = out_valid_q;
  assign out_found_o          = out_found_q;
  assign out_result_address_o = out_addr_q;
  assign out_out_of_range_o   = out_oor_q;

  // A rejected address never reports a hit.
  a_oor_not_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_found_o && out_out_of_range_o))
    else $error("out-of-range result reports found");

  // A result without a hit carries a zero address.
  a_miss_zero_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_found_o) |-> (out_result_address_o == '0))
    else $error("non-zero address on a miss");

  // A transfer on the input always starts work on the item.
  a_xfer_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("block idle after an input transfer");

endmodule

`default_nettype wire
